### hw/rtl/ssp_pkg.sv
package ssp_pkg;

    // field widths fixed by the register map and the stream format
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int LEN_W      = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LENGTH = 2'd3;

    // stream phase
    typedef enum logic [3:0] {
        PH_SKIP    = 4'b0001,
        PH_SEARCH  = 4'b0010,
        PH_CAPTURE = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    // one input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } beat_t;

    // configuration register contents
    typedef struct packed {
        logic [COUNT_W-1:0]    skip_count;
        logic [LEN_W-1:0]      sig_length;
        logic [CFG_DATA_W-1:0] signature_bytes;
        logic [COUNT_W-1:0]    capture_length;
    } cfg_t;

endpackage

### hw/rtl/ssp_if.sv
// input byte stream channel
interface ssp_in_if;
    logic                       valid;
    logic                       ready;
    logic [ssp_pkg::BYTE_W-1:0] data_byte;
    logic                       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// captured byte result channel
interface ssp_out_if;
    logic                       valid;
    logic                       ready;
    logic [ssp_pkg::BYTE_W-1:0] out_byte;
    logic                       found;
    logic                       last;

    modport source (output valid, output out_byte, output found, output last, input ready);
    modport sink   (input valid, input out_byte, input found, input last, output ready);
endinterface

### hw/rtl/ssp_cfg_regs.sv
module ssp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssp_pkg::cfg_t                      cfg
);

    ssp_pkg::cfg_t cfg_reg;
    ssp_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ssp_pkg::REG_SKIP_COUNT:
                    cfg_next.skip_count = cfg_data[ssp_pkg::COUNT_W-1:0];
                ssp_pkg::REG_SIG_LENGTH:
                    cfg_next.sig_length = cfg_data[ssp_pkg::LEN_W-1:0];
                ssp_pkg::REG_SIGNATURE:
                    cfg_next.signature_bytes = cfg_data;
                ssp_pkg::REG_CAPTURE_LENGTH:
                    cfg_next.capture_length = cfg_data[ssp_pkg::COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_count      <= '0;
            cfg_reg.sig_length      <= ssp_pkg::LEN_W'(1);
            cfg_reg.signature_bytes <= '0;
            cfg_reg.capture_length  <= ssp_pkg::COUNT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/ssp_in_reg.sv
module ssp_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    ssp_in_if.sink         in_stream,
    input  logic           advance,
    output logic           beat_valid,
    output ssp_pkg::beat_t beat
);

    logic           valid_reg;
    ssp_pkg::beat_t beat_reg;

    // a held beat leaves when the engine takes it, freeing the slot in the same cycle
    assign in_stream.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_stream.ready)
        begin
            valid_reg <= in_stream.valid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_stream.ready && in_stream.valid)
        begin
            beat_reg.data_byte     <= in_stream.data_byte;
            beat_reg.end_of_stream <= in_stream.end_of_stream;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

### hw/rtl/ssp_match.sv
module ssp_match #(
    parameter int SIG_MAX_BYTES = 8
) (
    input  logic [8*SIG_MAX_BYTES-1:0]        window,
    input  logic [$clog2(SIG_MAX_BYTES+1)-1:0] fill,
    input  logic [ssp_pkg::LEN_W-1:0]          eff_len,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]     signature,
    output logic                               match
);

    localparam int IDX_W = (SIG_MAX_BYTES > 1) ? $clog2(SIG_MAX_BYTES) : 1;

    logic [ssp_pkg::BYTE_W-1:0] win_b [SIG_MAX_BYTES];
    logic [ssp_pkg::BYTE_W-1:0] sig_b [SIG_MAX_BYTES];
    logic [SIG_MAX_BYTES-1:0]   byte_ok;

    // split window and signature into bytes
    always_comb
    begin
        for (int k = 0; k < SIG_MAX_BYTES; k++)
        begin
            win_b[k] = window[8*k +: 8];
            sig_b[k] = signature[8*k +: 8];
        end
    end

    // signature byte k lines up with window byte k + max - len (newest bytes on top)
    always_comb
    begin
        logic [4:0]       pos_wide;
        logic [IDX_W-1:0] pos;
        for (int k = 0; k < SIG_MAX_BYTES; k++)
        begin
            pos_wide   = 5'(k) + 5'(SIG_MAX_BYTES) - 5'(eff_len);
            pos        = pos_wide[IDX_W-1:0];
            byte_ok[k] = (5'(k) >= 5'(eff_len)) || (win_b[pos] == sig_b[k]);
        end
    end

    assign match = (ssp_pkg::LEN_W'(fill) >= eff_len) && (&byte_ok);

endmodule

### hw/rtl/ssp_engine.sv
module ssp_engine #(
    parameter int SIG_MAX_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ssp_pkg::cfg_t  cfg,
    input  logic           beat_valid,
    input  ssp_pkg::beat_t beat,
    output logic           advance,
    ssp_out_if.source      out_stream
);

    localparam int WIN_W  = 8 * SIG_MAX_BYTES;
    localparam int FILL_W = $clog2(SIG_MAX_BYTES + 1);

    ssp_pkg::phase_t                 phase_reg, phase_next;
    logic [ssp_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIN_W-1:0]                win_reg, win_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;

    logic                            out_valid_reg;
    logic [ssp_pkg::BYTE_W-1:0]      out_byte_reg;
    logic                            found_reg;
    logic                            last_reg;

    logic                            res_valid;
    logic [ssp_pkg::BYTE_W-1:0]      res_byte;
    logic                            res_found;
    logic                            res_last;

    logic [ssp_pkg::LEN_W-1:0]       eff_len;
    logic [WIN_W+7:0]                win_cat;
    logic [WIN_W-1:0]                win_shift;
    logic [FILL_W-1:0]               fill_inc;
    logic                            match;

    // the held beat moves on once the result slot is free or being emptied
    assign advance = beat_valid && (!out_valid_reg || out_stream.ready);

    // signature length clamped to 1..max
    always_comb
    begin
        if (cfg.sig_length == '0)
            eff_len = ssp_pkg::LEN_W'(1);
        else if (cfg.sig_length > ssp_pkg::LEN_W'(SIG_MAX_BYTES))
            eff_len = ssp_pkg::LEN_W'(SIG_MAX_BYTES);
        else
            eff_len = cfg.sig_length;
    end

    // new byte enters the top octet
    assign win_cat   = {beat.data_byte, win_reg} >> 8;
    assign win_shift = win_cat[WIN_W-1:0];
    assign fill_inc  = (fill_reg < FILL_W'(SIG_MAX_BYTES)) ? fill_reg + FILL_W'(1) : fill_reg;

    ssp_match #(
        .SIG_MAX_BYTES (SIG_MAX_BYTES)
    ) u_match (
        .window    (win_shift),
        .fill      (fill_inc),
        .eff_len   (eff_len),
        .signature (cfg.signature_bytes),
        .match     (match)
    );

    // per-beat phase update and result
    always_comb
    begin
        ssp_pkg::phase_t             phase_a;
        logic [ssp_pkg::COUNT_W-1:0] cnt_a;
        logic [ssp_pkg::COUNT_W-1:0] cap_eff;
        logic [ssp_pkg::COUNT_W:0]   cnt_inc;
        logic                        fin;

        phase_a   = phase_reg;
        cnt_a     = cnt_reg;
        win_next  = win_reg;
        fill_next = fill_reg;
        res_valid = 1'b0;
        res_byte  = beat.data_byte;
        res_found = 1'b1;
        res_last  = 1'b0;
        cap_eff   = (cfg.capture_length == '0) ? ssp_pkg::COUNT_W'(1) : cfg.capture_length;
        cnt_inc   = {1'b0, cnt_reg} + (ssp_pkg::COUNT_W+1)'(1);
        fin       = cnt_inc >= {1'b0, cap_eff};

        // skip phase: count off bytes, the first byte past the skip is searched at once
        if (phase_reg == ssp_pkg::PH_SKIP)
        begin
            if (cnt_reg < cfg.skip_count)
                cnt_a = cnt_inc[ssp_pkg::COUNT_W-1:0];
            else
                phase_a = ssp_pkg::PH_SEARCH;
        end

        phase_next = phase_a;
        cnt_next   = cnt_a;

        if (phase_a == ssp_pkg::PH_SEARCH)
        begin
            win_next  = win_shift;
            fill_next = fill_inc;
            if (match)
            begin
                phase_next = ssp_pkg::PH_CAPTURE;
                cnt_next   = '0;
            end
        end
        else if (phase_a == ssp_pkg::PH_CAPTURE)
        begin
            if (fin || !beat.end_of_stream)
            begin
                res_valid = 1'b1;
                res_last  = fin;
            end
            cnt_next = cnt_inc[ssp_pkg::COUNT_W-1:0];
            if (fin)
                phase_next = ssp_pkg::PH_DONE;
        end

        // end of stream: failure if nothing was completed, then re-arm
        if (beat.end_of_stream)
        begin
            if (!res_valid && phase_next != ssp_pkg::PH_DONE)
            begin
                res_valid = 1'b1;
                res_byte  = '0;
                res_found = 1'b0;
                res_last  = 1'b1;
            end
            phase_next = ssp_pkg::PH_SKIP;
            cnt_next   = '0;
            win_next   = '0;
            fill_next  = '0;
        end
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ssp_pkg::PH_SKIP;
            cnt_reg   <= '0;
            win_reg   <= '0;
            fill_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_byte_reg <= res_byte;
            found_reg    <= res_found;
            last_reg     <= res_last;
        end
    end

    assign out_stream.valid    = out_valid_reg;
    assign out_stream.out_byte = out_byte_reg;
    assign out_stream.found    = found_reg;
    assign out_stream.last     = last_reg;

endmodule

### hw/rtl/signature_search_payload_capture_unit.sv
// Signature search with payload capture on a byte stream.
// in_stream carries one byte per beat with an end_of_stream flag. At the start of
// each stream skip_count bytes are dropped, then a sliding search looks for the
// signature (sig_length bytes of signature_bytes, first byte lowest). After a hit
// the next capture_length bytes leave on out_stream with found set, the final one
// with last set. A stream that ends before the capture is complete gives a single
// beat with found low, last high and out_byte zero. Bytes after a complete capture
// give nothing; the block re-arms after every end_of_stream.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block idles, which the block itself does not enforce. A byte is
// accepted into the input register; its result is then registered in the result
// register when the engine takes the byte. Throughput: one byte per cycle unless
// out_stream stalls; phase, counter and match window are updated together per byte.
// Reset returns the registers to their defaults and the search to the skip phase.
// When out_stream stalls, the result holds and one further byte is held in the
// input register; in_stream.ready then drops until the result is taken.
module signature_search_payload_capture_unit #(
    parameter int SIG_MAX_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ssp_in_if.sink                         in_stream,
    ssp_out_if.source                      out_stream,
    input  logic                           cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data
);

    ssp_pkg::cfg_t  cfg;
    ssp_pkg::beat_t beat;
    logic           beat_valid;
    logic           advance;

    // configuration registers
    ssp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input beat register
    ssp_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // search, capture and result register
    ssp_engine #(
        .SIG_MAX_BYTES (SIG_MAX_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .advance    (advance),
        .out_stream (out_stream)
    );

endmodule

### hw/rtl/ssp_checker.sv
module ssp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ssp_pkg::BYTE_W-1:0] out_byte,
    input logic                       found,
    input logic                       last
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(found) && $stable(last))
        else $error("result payload changed while stalled");

    // a failure beat is always final and carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && out_byte == '0)
        else $error("malformed failure beat");

    // a rising out_valid comes from a byte taken via the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input beat");

endmodule

bind signature_search_payload_capture_unit ssp_checker u_ssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_byte  (out_stream.out_byte),
    .found     (out_stream.found),
    .last      (out_stream.last)
);

### tb/tb_signature_search_payload_capture_unit.sv
`timescale 1ns / 100ps

module tb_signature_search_payload_capture_unit;

    localparam int SIG_BYTES     = 8;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 50;

    // one captured beat as it should leave the block
    typedef struct packed {
        logic [ssp_pkg::BYTE_W-1:0] out_byte;
        logic                       found;
        logic                       last;
    } capture_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data;

    ssp_in_if  in_if ();
    ssp_out_if out_if ();

    signature_search_payload_capture_unit #(
        .SIG_MAX_BYTES (SIG_BYTES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ssp_pkg::beat_t pending_beats[$];
    capture_beat_t  expected_captures[$];
    logic [7:0]     stream_bytes[$];
    ssp_pkg::beat_t next_beat;
    capture_beat_t  oldest_capture;

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int cycle_count;

    // shadow of the registers and of the search state
    ssp_pkg::cfg_t   cfg_shadow;
    ssp_pkg::phase_t trk_phase;
    logic [15:0]     trk_count;
    logic [63:0]     trk_window;
    logic [3:0]      trk_fill;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int eff_sig_len();
        if (cfg_shadow.sig_length == 4'd0)
            return 1;
        if (int'(cfg_shadow.sig_length) > SIG_BYTES)
            return SIG_BYTES;
        return int'(cfg_shadow.sig_length);
    endfunction

    function automatic int eff_capture_len();
        if (cfg_shadow.capture_length == 16'd0)
            return 1;
        return int'(cfg_shadow.capture_length);
    endfunction

    function automatic logic [7:0] sig_byte(input int idx);
        return cfg_shadow.signature_bytes[8 * idx +: 8];
    endfunction

    // random byte, half the time drawn from the signature to seed partial matches
    function automatic logic [7:0] noise_byte();
        int idx;
        idx = $urandom_range(0, eff_sig_len() - 1);
        if ($urandom_range(0, 1) == 1)
            return sig_byte(idx);
        return 8'($urandom);
    endfunction

    task automatic rearm_tracker();
        trk_phase  = ssp_pkg::PH_SKIP;
        trk_count  = '0;
        trk_window = '0;
        trk_fill   = '0;
    endtask

    // advance the search by one accepted byte and queue what it yields
    task automatic track_stream_byte(input logic [7:0] b, input logic eos);
        int          len;
        logic [63:0] mask;
        logic [63:0] tail;
        logic [16:0] next_count;
        logic        fin;
        logic        emitted;
        emitted = 1'b0;
        if (trk_phase == ssp_pkg::PH_SKIP)
        begin
            if (trk_count < cfg_shadow.skip_count)
                trk_count = trk_count + 16'd1;
            else
                trk_phase = ssp_pkg::PH_SEARCH;
        end
        if (trk_phase == ssp_pkg::PH_SEARCH)
        begin
            len        = eff_sig_len();
            trk_window = {b, trk_window[63:8]};
            if (int'(trk_fill) < SIG_BYTES)
                trk_fill = trk_fill + 4'd1;
            mask = (len >= SIG_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            tail = (trk_window >> (8 * (SIG_BYTES - len))) & mask;
            if (int'(trk_fill) >= len && tail == (cfg_shadow.signature_bytes & mask))
            begin
                trk_phase = ssp_pkg::PH_CAPTURE;
                trk_count = '0;
            end
        end
        else if (trk_phase == ssp_pkg::PH_CAPTURE)
        begin
            next_count = {1'b0, trk_count} + 17'd1;
            fin        = (int'(next_count) >= eff_capture_len());
            if (fin || !eos)
            begin
                expected_captures.push_back(capture_beat_t'{out_byte: b, found: 1'b1, last: fin});
                emitted = 1'b1;
            end
            trk_count = next_count[15:0];
            if (fin)
                trk_phase = ssp_pkg::PH_DONE;
        end
        // stream end: failure unless the capture already finished
        if (eos)
        begin
            if (!emitted && trk_phase != ssp_pkg::PH_DONE)
                expected_captures.push_back(capture_beat_t'{out_byte: '0, found: 1'b0, last: 1'b1});
            rearm_tracker();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        end
    endtask

    // input driver, fed from the pending beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid         <= 1'b0;
            in_if.data_byte     <= '0;
            in_if.end_of_stream <= 1'b0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
                track_stream_byte(in_if.data_byte, in_if.end_of_stream);
            if (!in_if.valid || in_if.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    next_beat            = pending_beats.pop_front();
                    in_if.valid         <= 1'b1;
                    in_if.data_byte     <= next_beat.data_byte;
                    in_if.end_of_stream <= next_beat.end_of_stream;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_captures.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $error("unexpected result beat: out_byte %0h found %0b last %0b",
                               out_if.out_byte, out_if.found, out_if.last);
                end
                else
                begin
                    oldest_capture = expected_captures.pop_front();
                    check_field("out_byte", oldest_capture.out_byte, out_if.out_byte);
                    check_field("found", 8'(oldest_capture.found), 8'(out_if.found));
                    check_field("last", 8'(oldest_capture.last), 8'(out_if.last));
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** signature_search_payload_capture_unit: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [ssp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssp_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ssp_pkg::REG_SKIP_COUNT:     cfg_shadow.skip_count      = value[15:0];
            ssp_pkg::REG_SIG_LENGTH:     cfg_shadow.sig_length      = value[3:0];
            ssp_pkg::REG_SIGNATURE:      cfg_shadow.signature_bytes = value;
            ssp_pkg::REG_CAPTURE_LENGTH: cfg_shadow.capture_length  = value[15:0];
            default:                     ;
        endcase
    endtask

    // all four registers, unused upper bits filled with junk
    task automatic set_config(input int skip, input int len, input logic [63:0] sig, input int cap);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(ssp_pkg::REG_SKIP_COUNT, {junk[63:16], 16'(skip)});
        junk = {$urandom, $urandom};
        write_reg(ssp_pkg::REG_SIG_LENGTH, {junk[63:4], 4'(len)});
        write_reg(ssp_pkg::REG_SIGNATURE, sig);
        junk = {$urandom, $urandom};
        write_reg(ssp_pkg::REG_CAPTURE_LENGTH, {junk[63:16], 16'(cap)});
    endtask

    // hold off until every beat is in and every result out, then let the pipeline settle
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_if.valid || expected_captures.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // hand the built stream to the driver, end flag on its final byte
    task automatic queue_stream();
        int i;
        @(negedge clk);
        for (i = 0; i < stream_bytes.size(); i++)
            pending_beats.push_back(ssp_pkg::beat_t'{data_byte: stream_bytes[i],
                                    end_of_stream: (i == stream_bytes.size() - 1)});
        stream_bytes.delete();
    endtask

    // one random stream: mostly well formed, some noise, some cut short
    task automatic gen_stream(output int counted);
        int len;
        int cap;
        int kind;
        int i;
        len  = eff_sig_len();
        cap  = eff_capture_len();
        kind = $urandom_range(0, 99);
        stream_bytes.delete();
        if (kind < 70)
        begin
            repeat (cfg_shadow.skip_count) stream_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 4)) stream_bytes.push_back(noise_byte());
            for (i = 0; i < len; i++)
                stream_bytes.push_back(sig_byte(i));
            repeat ($urandom_range(0, cap + 2)) stream_bytes.push_back(8'($urandom));
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(1, 10)) stream_bytes.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, cfg_shadow.skip_count)) stream_bytes.push_back(8'($urandom));
            for (i = 0; i < $urandom_range(0, len - 1); i++)
                stream_bytes.push_back(sig_byte(i));
        end
        if (stream_bytes.size() == 0)
            stream_bytes.push_back(8'($urandom));
        counted = stream_bytes.size();
        queue_stream();
    endtask

    // stimulus
    initial
    begin
        int items;
        int n;
        int i;
        int pick;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.end_of_stream = 1'b0;
        out_if.ready        = 1'b0;
        mismatches          = 0;
        cycle_count         = 0;
        src_idle_pct        = 29;
        sink_idle_pct       = 88;
        cfg_shadow          = ssp_pkg::cfg_t'{skip_count: 16'd0, sig_length: 4'd1,
                                              signature_bytes: 64'd0, capture_length: 16'd1};
        rearm_tracker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: zero signature of one byte, one byte captured
        stream_bytes = '{8'h00, 8'hA7};
        queue_stream();
        // end during search
        stream_bytes = '{8'hFF};
        queue_stream();
        // match on the final byte
        stream_bytes = '{8'h00};
        queue_stream();

        // skip of two, three byte signature with junk above, end during capture
        wait_idle();
        set_config(2, 3, 64'hDEAD_BEEF_00A5_5AC3, 3);
        stream_bytes = '{8'h11, 8'h22, 8'hC3, 8'h5A, 8'hA5, 8'h01, 8'h02};
        queue_stream();
        // end during skip
        stream_bytes = '{8'h11};
        queue_stream();

        // zero length and zero capture act as one; bytes after the capture ignored
        wait_idle();
        set_config(0, 0, 64'h1234_5678_9ABC_DE80, 0);
        stream_bytes = '{8'h80, 8'hFF, 8'h00};
        queue_stream();

        // length above the maximum acts as the full eight bytes
        wait_idle();
        set_config(0, 15, 64'hF0E1_D2C3_B4A5_9687, 2);
        stream_bytes = '{8'h87, 8'h96, 8'hA5, 8'hB4, 8'hC3, 8'hD2, 8'hE1, 8'hF0, 8'h55, 8'hAA};
        queue_stream();

        // random streams in groups, a fresh setting between groups
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            wait_idle();
            if (items < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 29;
                sink_idle_pct = 88;
            end
            else if (items < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 88;
                sink_idle_pct = 29;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            pick = $urandom_range(0, 9);
            set_config((pick < 4) ? 0 : ((pick < 9) ? $urandom_range(1, 6) : $urandom_range(7, 40)),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                       {$urandom, $urandom},
                       ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6));
            repeat ($urandom_range(6, 12))
            begin
                gen_stream(n);
                items += n;
            end
        end

        // long skip and a capture counted past one byte
        wait_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_config(300, 8, {$urandom, $urandom}, 260);
        repeat (300) stream_bytes.push_back(8'($urandom));
        for (i = 0; i < SIG_BYTES; i++)
            stream_bytes.push_back(sig_byte(i));
        repeat (260) stream_bytes.push_back(8'($urandom));
        queue_stream();

        // largest skip, stream ends while skipping
        wait_idle();
        set_config(65535, 8, {$urandom, $urandom}, 65535);
        repeat (5) stream_bytes.push_back(8'($urandom));
        queue_stream();

        // largest capture, stream ends while capturing
        wait_idle();
        set_config(0, 8, {$urandom, $urandom}, 65535);
        for (i = 0; i < SIG_BYTES; i++)
            stream_bytes.push_back(sig_byte(i));
        repeat (4) stream_bytes.push_back(8'($urandom));
        queue_stream();

        wait_idle();
        if (mismatches == 0)
            $display("** signature_search_payload_capture_unit: PASSED **");
        else
            $display("** signature_search_payload_capture_unit: FAILED **");
        $finish;
    end

endmodule
